>>> rtl/core/lli_pkg.sv
`timescale 1ns / 1ps

package lli_pkg;

  localparam int VOLT_W        = 16;
  localparam int CODE_W        = 12;
  localparam int TABLE_ENTRIES = 18;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // Breakpoints sit one volt apart, so every segment spans VOLT_STEP in Q8.8.
  localparam int VOLT_FIRST = 512;
  localparam int STEP_LOG2  = 8;
  localparam int VOLT_STEP  = 1 << STEP_LOG2;
  localparam int HALF_STEP  = VOLT_STEP / 2;
  localparam int PROD_W     = STEP_LOG2 + CODE_W;

  // Calibration codes, rising with voltage.
  localparam logic [CODE_W-1:0] CAL_CODE [TABLE_ENTRIES] = '{
    12'd320,  12'd470,  12'd625,  12'd785,  12'd950,  12'd1125,
    12'd1330, 12'd1518, 12'd1680, 12'd1820, 12'd1970, 12'd2110,
    12'd2212, 12'd2295, 12'd2445, 12'd2595, 12'd2745, 12'd2900
  };

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  function automatic logic [VOLT_W-1:0] volt_at(input logic [IDX_W-1:0] idx);
    return VOLT_W'(VOLT_FIRST + (int'(idx) << STEP_LOG2));
  endfunction

  // Register indexes on the configuration port.
  localparam logic REG_REF_MIN = 1'b0;
  localparam logic REG_REF_MAX = 1'b1;

  localparam logic [VOLT_W-1:0] REF_MIN_RESET = 16'd512;
  localparam logic [VOLT_W-1:0] REF_MAX_RESET = 16'd4864;

  // Microcode
  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_CLAMP,
    OP_RANGE,
    OP_SEARCH,
    OP_MUL,
    OP_ROUND,
    OP_WRITE,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_OUTSIDE,
    COND_SEARCH_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  localparam logic [STEP_W-1:0] ST_ACCEPT = 3'd0;
  localparam logic [STEP_W-1:0] ST_SEARCH = 3'd3;
  localparam logic [STEP_W-1:0] ST_WRITE  = 3'd6;

  localparam uword_t UCODE [1 << STEP_W] = '{
    '{op: OP_ACCEPT, cond: COND_NO_INPUT,    target: ST_ACCEPT},
    '{op: OP_CLAMP,  cond: COND_NEVER,       target: ST_ACCEPT},
    '{op: OP_RANGE,  cond: COND_OUTSIDE,     target: ST_WRITE},
    '{op: OP_SEARCH, cond: COND_SEARCH_MORE, target: ST_SEARCH},
    '{op: OP_MUL,    cond: COND_NEVER,       target: ST_ACCEPT},
    '{op: OP_ROUND,  cond: COND_NEVER,       target: ST_ACCEPT},
    '{op: OP_WRITE,  cond: COND_OUT_BUSY,    target: ST_WRITE},
    '{op: OP_NOP,    cond: COND_ALWAYS,      target: ST_ACCEPT}
  };

endpackage

>>> rtl/core/lli_if.sv
`timescale 1ns / 1ps

interface lli_in_if;
  logic                       valid;
  logic                       ready;
  logic [lli_pkg::VOLT_W-1:0] voltage_request;

  modport source (output valid, output voltage_request, input ready);
  modport sink   (input valid, input voltage_request, output ready);
endinterface

interface lli_out_if;
  logic                       valid;
  logic                       ready;
  logic [lli_pkg::CODE_W-1:0] adc_reference;

  modport source (output valid, output adc_reference, input ready);
  modport sink   (input valid, input adc_reference, output ready);
endinterface

>>> rtl/core/lut_linear_interpolator.sv
`timescale 1ns / 1ps
// Voltage request (Q8.8) to 12-bit ADC reference code by table interpolation.
// Steps: accept, clamp and range check; a clamped value off either end of the table
//   goes straight to the write step, else binary search, multiply, round and write.
// Throughput: one item per microcode pass; no new item is taken before the pass is back
//   at the accept step, and a result not yet taken holds the pass at the write step.
// Reset (rst, synchronous): step 0, output empty, ref_min = 2.0 V, ref_max = 19.0 V.
module lut_linear_interpolator (
  input  logic              clk,
  input  logic              rst,
  lli_in_if.sink            in_ch,
  lli_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = lli_pkg::IDX_W;
  localparam int VW = lli_pkg::VOLT_W;
  localparam int CW = lli_pkg::CODE_W;
  localparam int PW = lli_pkg::PROD_W;

  // ---------------- configuration registers ----------------
  logic [VW-1:0] ref_min;
  logic [VW-1:0] ref_max;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];   // registers at byte addresses 0 and 4; only paddr[2] is decoded

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_min <= lli_pkg::REF_MIN_RESET;
      ref_max <= lli_pkg::REF_MAX_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == lli_pkg::REG_REF_MIN) begin
        ref_min <= pwdata[VW-1:0];
      end else begin
        ref_max <= pwdata[VW-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == lli_pkg::REG_REF_MIN) begin
      prdata = {16'd0, ref_min};
    end else begin
      prdata = {16'd0, ref_max};
    end
  end

  // ---------------- sequencer ----------------
  logic [lli_pkg::STEP_W-1:0] step;
  logic [lli_pkg::STEP_W-1:0] step_next;
  lli_pkg::uword_t            uw;

  assign uw = lli_pkg::UCODE[step];

  // ---------------- datapath ----------------
  logic [VW-1:0] volt;        // request, then clamped request
  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic [PW-1:0] prod;        // dv * dc
  logic [CW-1:0] res;
  logic [CW-1:0] out_code;
  logic          out_valid;

  logic [IW-1:0]   mid;
  logic            search_more;
  logic            below, above;
  logic            out_busy;
  logic [lli_pkg::STEP_LOG2-1:0] dv;
  logic [CW-1:0]   dc;
  logic [PW:0]     rounded;

  assign mid         = IW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign search_more = ({1'b0, lo} + 1'b1) < {1'b0, hi};
  assign below       = volt <= lli_pkg::volt_at('0);
  assign above       = volt >= lli_pkg::volt_at(lli_pkg::IDX_LAST);
  assign out_busy    = out_valid && !out_ch.ready;

  // Inside a segment v - V[lo] stays below one step, so its low bits are all of it.
  assign dv      = lli_pkg::STEP_LOG2'(volt - lli_pkg::volt_at(lo));
  assign dc      = lli_pkg::CAL_CODE[hi] - lli_pkg::CAL_CODE[lo];
  // (2*dv*dc + den) / (2*den) with den = one step: round half up, then shift.
  assign rounded = {1'b0, prod} + (PW + 1)'(lli_pkg::HALF_STEP);

  // no item is taken while reset holds the program at step 0
  assign in_ch.ready = (uw.op == lli_pkg::OP_ACCEPT) && !rst;

  // jump decision
  always_comb begin
    logic take;
    take = 1'b0;
    case (uw.cond)
      lli_pkg::COND_NEVER:       take = 1'b0;
      lli_pkg::COND_ALWAYS:      take = 1'b1;
      lli_pkg::COND_NO_INPUT:    take = !in_ch.valid;
      lli_pkg::COND_OUTSIDE:     take = below || above;
      lli_pkg::COND_SEARCH_MORE: take = search_more;
      lli_pkg::COND_OUT_BUSY:    take = out_busy;
      default:                   take = 1'b0;
    endcase
    step_next = take ? uw.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lli_pkg::ST_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      lli_pkg::OP_ACCEPT: begin
        volt <= in_ch.voltage_request;
        lo   <= '0;
        hi   <= lli_pkg::IDX_LAST;
      end
      lli_pkg::OP_CLAMP: begin
        // upper limit wins when the limits cross
        if (volt > ref_max) begin
          volt <= ref_max;
        end else if (volt < ref_min) begin
          volt <= ref_min;
        end
      end
      lli_pkg::OP_RANGE: begin
        if (below) begin
          res <= lli_pkg::CAL_CODE[0];
        end else if (above) begin
          res <= lli_pkg::CAL_CODE[lli_pkg::IDX_LAST];
        end
      end
      lli_pkg::OP_SEARCH: begin
        if (search_more) begin
          if (volt < lli_pkg::volt_at(mid)) begin
            hi <= mid;
          end else begin
            lo <= mid;
          end
        end
      end
      lli_pkg::OP_MUL: begin
        prod <= PW'(dv) * PW'(dc);
      end
      lli_pkg::OP_ROUND: begin
        res <= lli_pkg::CAL_CODE[lo] + CW'(rounded >> lli_pkg::STEP_LOG2);
      end
      default: begin
      end
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == lli_pkg::OP_WRITE && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == lli_pkg::OP_WRITE && !out_busy) begin
      out_code <= res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.adc_reference = out_code;

endmodule

>>> bench/lut_linear_interpolator_tb.sv
`timescale 1ns / 1ps

module lut_linear_interpolator_tb;

  localparam int VW = lli_pkg::VOLT_W;
  localparam int CW = lli_pkg::CODE_W;

  // Calibration codes at 2 V .. 19 V, one volt apart (independent copy).
  localparam int BREAK_CODE [18] = '{
    320, 470, 625, 785, 950, 1125, 1330, 1518, 1680,
    1820, 1970, 2110, 2212, 2295, 2445, 2595, 2745, 2900
  };
  localparam int FIRST_VOLT = 512;   // 2.0 V in Q8.8
  localparam int LAST_VOLT  = 4864;  // 19.0 V in Q8.8
  localparam int RANDOM_PER_SETTING = 147;

  // Predicts the ADC reference code for each accepted voltage request and
  // holds the codes still owed by the block, oldest first.
  class adc_code_board;
    logic [VW-1:0] lo_limit;
    logic [VW-1:0] hi_limit;
    logic [CW-1:0] code_q[$];
    int errors;
    int requests;
    int codes_seen;

    function new();
      lo_limit   = lli_pkg::REF_MIN_RESET;
      hi_limit   = lli_pkg::REF_MAX_RESET;
      errors     = 0;
      requests   = 0;
      codes_seen = 0;
    endfunction

    function logic [CW-1:0] predict_code(input logic [VW-1:0] req);
      logic [VW-1:0] v;
      int seg;
      int dv;
      int c0;
      int dc;
      v = req;
      // max wins over min, even when the limits are inverted
      if (v > hi_limit) v = hi_limit;
      else if (v < lo_limit) v = lo_limit;
      if (int'(v) <= FIRST_VOLT) return CW'(BREAK_CODE[0]);
      if (int'(v) >= LAST_VOLT) return CW'(BREAK_CODE[17]);
      seg = (int'(v) - FIRST_VOLT) >> 8;
      dv  = (int'(v) - FIRST_VOLT) & 255;
      c0  = BREAK_CODE[seg];
      dc  = BREAK_CODE[seg + 1] - c0;
      // segment width is 256, round half up
      return CW'(c0 + (2 * dv * dc + 256) / 512);
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task note_request(input logic [VW-1:0] req);
      code_q.push_back(predict_code(req));
      requests++;
    endtask

    task check_code(input logic [CW-1:0] code);
      logic [CW-1:0] want;
      codes_seen++;
      if (code_q.size() == 0) begin
        report($sformatf("unexpected code %0d", code));
      end else begin
        want = code_q.pop_front();
        if (code !== want)
          report($sformatf("adc_reference %0d, expected %0d", code, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lli_in_if  req_ch ();
  lli_out_if code_ch ();

  lut_linear_interpolator dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (req_ch),
    .out_ch  (code_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  adc_code_board board = new();

  // stall switches: redrawn every few dozen items so bursts with no idling
  // alternate with stretches of random gaps
  bit send_gaps;
  bit take_stalls;
  int settings_run;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run of about 1100 items.
  initial begin
    #5ms;
    $display("** lut_linear_interpolator: FAILED **");
    $finish;
  end

  // Code sink: random ready stalls before each item while stalls are switched on.
  initial begin
    int n;
    int k;
    k = 0;
    wait (rst == 1'b0);
    forever begin
      if (k % 37 == 0) take_stalls = ($urandom_range(0, 3) != 0);
      k++;
      n = take_stalls ? $urandom_range(0, 18) : 0;
      if (n > 0) begin
        code_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      code_ch.ready <= 1'b1;
      do @(posedge clk); while (!(code_ch.valid && code_ch.ready));
      board.check_code(code_ch.adc_reference);
    end
  end

  // One voltage request item; valid stays high on return so back-to-back
  // items need no extra NBA in the same step.
  task send_request(input logic [VW-1:0] v);
    int n;
    n = send_gaps ? $urandom_range(0, 18) : 0;
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.voltage_request <= v;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    board.note_request(v);
  endtask

  // Drop valid and wait until every owed code is back, plus the pipeline tail.
  task drain_codes();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (board.code_q.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  // APB write; upper pwdata bits carry junk, only [15:0] are the register.
  task write_limit(input logic idx, input logic [VW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == lli_pkg::REG_REF_MIN) board.lo_limit = val;
    else board.hi_limit = val;
    @(posedge clk);
  endtask

  task read_limit(input logic idx);
    logic [31:0] want;
    want = {16'd0, (idx == lli_pkg::REG_REF_MIN) ? board.lo_limit : board.hi_limit};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      board.report($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                             idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task set_limits(input logic [VW-1:0] lo, input logic [VW-1:0] hi);
    write_limit(lli_pkg::REG_REF_MIN, lo);
    write_limit(lli_pkg::REG_REF_MAX, hi);
    read_limit(lli_pkg::REG_REF_MIN);
    read_limit(lli_pkg::REG_REF_MAX);
    settings_run++;
  endtask

  // Random request mix: full 16-bit range, the table span, around
  // breakpoints, around the current limits and the two range extremes.
  function automatic logic [VW-1:0] pick_request();
    int mode;
    int v;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: v = $urandom_range(0, 65535);
      3, 4, 5, 6: v = $urandom_range(0, 5400);
      7: v = FIRST_VOLT + 256 * $urandom_range(0, 17) + $urandom_range(0, 6) - 3;
      8: begin
        v = ($urandom_range(0, 1) ? int'(board.lo_limit) : int'(board.hi_limit))
            + $urandom_range(0, 4) - 2;
      end
      default: v = $urandom_range(0, 1) ? 0 : 65535;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return VW'(v);
  endfunction

  task random_requests(input int count, input bit hold_off);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) send_gaps = ($urandom_range(0, 3) != 0);
      send_request(pick_request());
      // let the block run dry now and then before the next item
      if (hold_off && k % 50 == 49) drain_codes();
    end
    drain_codes();
  endtask

  // Clamp edges, table ends, breakpoints and exact half-way rounding points.
  localparam int EDGE_REQ [23] = '{
    0, 1, 257, 511, 512, 513, 575, 576, 577, 768, 1280, 1920,
    2560, 3103, 3104, 3105, 4608, 4863, 4864, 4865, 5000, 32768, 65535
  };

  initial begin
    logic [VW-1:0] lo;
    logic [VW-1:0] hi;
    settings_run = 1;
    send_gaps    = 1'b0;
    take_stalls  = 1'b0;
    req_ch.valid           <= 1'b0;
    req_ch.voltage_request <= '0;
    code_ch.ready          <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst     <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limits: check they read back, then directed edges
    read_limit(lli_pkg::REG_REF_MIN);
    read_limit(lli_pkg::REG_REF_MAX);
    foreach (EDGE_REQ[i]) send_request(VW'(EDGE_REQ[i]));
    drain_codes();
    random_requests(RANDOM_PER_SETTING, 1'b1);

    // no clamping at all: whole table and both flat ends reachable
    set_limits(16'd0, 16'hFFFF);
    foreach (EDGE_REQ[i]) send_request(VW'(EDGE_REQ[i]));
    random_requests(RANDOM_PER_SETTING, 1'b0);

    // both limits at the bottom, then both at the top
    set_limits(16'd0, 16'd0);
    random_requests(RANDOM_PER_SETTING / 2, 1'b0);
    set_limits(16'hFFFF, 16'hFFFF);
    random_requests(RANDOM_PER_SETTING / 2, 1'b0);

    // inverted limits: max is applied first
    set_limits(16'd3000, 16'd1200);
    random_requests(RANDOM_PER_SETTING, 1'b0);

    // narrow window inside the table
    set_limits(16'd1000, 16'd3500);
    random_requests(RANDOM_PER_SETTING, 1'b1);

    // random windows, inverted ones included
    for (int s = 0; s < 2; s++) begin
      lo = VW'($urandom_range(0, 6000));
      hi = VW'($urandom_range(0, 6000));
      set_limits(lo, hi);
      random_requests(RANDOM_PER_SETTING, 1'b0);
    end

    $display("Checked %0d codes for %0d voltage requests over %0d limit settings,",
             board.codes_seen, board.requests, settings_run);
    $display("including inverted, collapsed and full-range clamp windows.");
    if (board.errors == 0 && board.code_q.size() == 0) begin
      $display("** lut_linear_interpolator: PASSED **");
    end else begin
      $display("%0d mismatches, %0d codes never arrived",
               board.errors, board.code_q.size());
      $display("** lut_linear_interpolator: FAILED **");
    end
    $finish;
  end

endmodule
